>>> rtl/core/grid_point_accumulator_macros.svh
// Assertion macros for the grid point accumulator RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef GRID_POINT_ACCUMULATOR_MACROS_SVH
`define GRID_POINT_ACCUMULATOR_MACROS_SVH

`ifndef SYNTHESIS

`define GPA_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
		else $error("assertion failed");

`define GPA_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
		else $error("assertion failed");

`else

`define GPA_ASSERT_IMPLIES(label, clk, rst_n, cond, expr)

`define GPA_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

>>> rtl/core/gpa_pkg.sv
// Shared constants, codes and types of the grid point accumulator.
// No dependencies; imported by every module of the block.
package gpa_pkg;

	localparam int DEF_GRID_COLS  = 256;
	localparam int DEF_GRID_ROWS  = 256;
	localparam int DEF_CELL_WIDTH = 32;

	localparam int POS_W   = 32;
	localparam int SCALE_W = 16;
	localparam int CNT_W   = 9;
	localparam int IDX_W   = 8;
	localparam int CMD_W   = 2;
	localparam int REG_W   = 3;
	localparam int Q_SHIFT = 24;
	localparam int MAX_CNT = 256;

	localparam logic [CMD_W-1:0] CMD_ACC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RD  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_WR  = 2'd2;

	localparam logic [REG_W-1:0] REG_X_ORIGIN = 3'd0;
	localparam logic [REG_W-1:0] REG_Y_ORIGIN = 3'd1;
	localparam logic [REG_W-1:0] REG_X_SCALE  = 3'd2;
	localparam logic [REG_W-1:0] REG_Y_SCALE  = 3'd3;
	localparam logic [REG_W-1:0] REG_COLS     = 3'd4;
	localparam logic [REG_W-1:0] REG_ROWS     = 3'd5;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
	localparam logic [CNT_W-1:0]   CNT_RESET   = 9'd256;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} gpa_mem_ctl_t;

endpackage

>>> rtl/core/grid_point_accumulator.sv
// Grid point accumulator top level: configuration registers, command sequencer, cell update.
// Depends on gpa_pkg, gpa_quant, gpa_cell_mem and grid_point_accumulator_macros.svh.
//
// Usage:
//   Requests enter on s_tvalid/s_tready with the command in s_tuser and the point,
//   weight and cell address in s_tdata. Each request gives exactly one response on
//   m_tvalid/m_tready: cell value and cell position in m_tdata, hit and saturated in
//   m_tuser. Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data
//   and are taken in any cycle; write them only while no request is in flight.
//   One request is in flight at a time: the block takes no new request until the
//   current one has passed its three quantizer stages, one memory read and one
//   modify-write step.
//   Reset: configuration returns to its defaults and a clearing sweep writes zero to
//   every cell, one per cycle, GRID_COLS * GRID_ROWS cells (65536 by default);
//   s_tready stays low until it ends.
//   Stall: the response waits in the output register while m_tready is low; the next
//   request can already be taken and runs until its own modify-write step, where it
//   holds until the output register is free.
`include "grid_point_accumulator_macros.svh"

module grid_point_accumulator
	import gpa_pkg::*;
#(
	parameter int GRID_COLS  = DEF_GRID_COLS,
	parameter int GRID_ROWS  = DEF_GRID_ROWS,
	parameter int CELL_WIDTH = DEF_CELL_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [111:0]       s_tdata,   // pos_x, pos_y, weight, cell_col, cell_row
	input  logic [CMD_W-1:0]   s_tuser,   // cmd
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [47:0]        m_tdata,   // cell_value, out_col, out_row
	output logic [1:0]         m_tuser,   // hit, saturated
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [REG_W-1:0]   cfg_index,
	input  logic [POS_W-1:0]   cfg_data
);

	localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int SUM_W      = (CELL_WIDTH > POS_W ? CELL_WIDTH : POS_W) + 1;
	localparam int COL_CAP    = GRID_COLS < MAX_CNT ? GRID_COLS : MAX_CNT;
	localparam int ROW_CAP    = GRID_ROWS < MAX_CNT ? GRID_ROWS : MAX_CNT;
	localparam logic signed [SUM_W-1:0] CELL_HI =
		{{(SUM_W-CELL_WIDTH+1){1'b0}}, {(CELL_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] CELL_LO =
		{{(SUM_W-CELL_WIDTH+1){1'b1}}, {(CELL_WIDTH-1){1'b0}}};
	localparam logic signed [SUM_W-1:0] OUT_HI =
		{{(SUM_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] OUT_LO =
		{{(SUM_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_Q1,
		ST_Q2,
		ST_Q3,
		ST_RD,
		ST_MOD
	} state_t;

	state_t state_q;

	logic signed [POS_W-1:0] x_origin_q;
	logic signed [POS_W-1:0] y_origin_q;
	logic [SCALE_W-1:0]      x_scale_q;
	logic [SCALE_W-1:0]      y_scale_q;
	logic [CNT_W-1:0]        cols_q;
	logic [CNT_W-1:0]        rows_q;
	logic [CNT_W-1:0]        ncols;
	logic [CNT_W-1:0]        nrows;

	logic [CMD_W-1:0]        cmd_q;
	logic signed [POS_W-1:0] pos_x_q;
	logic signed [POS_W-1:0] pos_y_q;
	logic signed [POS_W-1:0] weight_q;
	logic [IDX_W-1:0]        cell_col_q;
	logic [IDX_W-1:0]        cell_row_q;

	logic                    qx_hit;
	logic                    qy_hit;
	logic [IDX_W-1:0]        qx_idx;
	logic [IDX_W-1:0]        qy_idx;

	logic                    hit_d;
	logic [IDX_W-1:0]        col_d;
	logic [IDX_W-1:0]        row_d;
	logic [ADDR_W-1:0]       addr_d;
	logic                    hit_q;
	logic [IDX_W-1:0]        col_q;
	logic [IDX_W-1:0]        row_q;
	logic [ADDR_W-1:0]       addr_q;

	gpa_mem_ctl_t            mem_ctl;
	logic signed [CELL_WIDTH-1:0] rd_data;
	logic [CELL_WIDTH-1:0]   rd_raw;
	logic                    mem_busy;

	logic signed [SUM_W-1:0] c_ext;
	logic signed [SUM_W-1:0] w_ext;
	logic signed [SUM_W-1:0] src;
	logic signed [SUM_W-1:0] clipped;
	logic                    sat_d;
	logic [POS_W-1:0]        val_d;
	logic                    done;
	logic                    accept;

	logic                    out_valid_q;
	logic                    out_hit_q;
	logic                    out_sat_q;
	logic [POS_W-1:0]        out_val_q;
	logic [IDX_W-1:0]        out_col_q;
	logic [IDX_W-1:0]        out_row_q;

	assign cfg_ready = 1'b1;
	assign ncols = (cols_q > CNT_W'(COL_CAP)) ? CNT_W'(COL_CAP) : cols_q;
	assign nrows = (rows_q > CNT_W'(ROW_CAP)) ? CNT_W'(ROW_CAP) : rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q <= '0;
			y_origin_q <= '0;
			x_scale_q  <= SCALE_RESET;
			y_scale_q  <= SCALE_RESET;
			cols_q     <= CNT_RESET;
			rows_q     <= CNT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_X_ORIGIN: x_origin_q <= cfg_data;
				REG_Y_ORIGIN: y_origin_q <= cfg_data;
				REG_X_SCALE:  x_scale_q  <= cfg_data[SCALE_W-1:0];
				REG_Y_SCALE:  y_scale_q  <= cfg_data[SCALE_W-1:0];
				REG_COLS:     cols_q     <= cfg_data[CNT_W-1:0];
				REG_ROWS:     rows_q     <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE) && !mem_busy;
	assign accept   = s_tvalid && s_tready;
	assign done     = !out_valid_q || m_tready;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= s_tuser;
			pos_x_q    <= s_tdata[31:0];
			pos_y_q    <= s_tdata[63:32];
			weight_q   <= s_tdata[95:64];
			cell_col_q <= s_tdata[103:96];
			cell_row_q <= s_tdata[111:104];
		end
	end

	gpa_quant u_quant_x (
		.clk    (clk),
		.pos    (pos_x_q),
		.origin (x_origin_q),
		.scale  (x_scale_q),
		.count  (ncols),
		.hit_s3 (qx_hit),
		.idx_s3 (qx_idx)
	);

	gpa_quant u_quant_y (
		.clk    (clk),
		.pos    (pos_y_q),
		.origin (y_origin_q),
		.scale  (y_scale_q),
		.count  (nrows),
		.hit_s3 (qy_hit),
		.idx_s3 (qy_idx)
	);

	always_comb begin
		hit_d = 1'b0;
		col_d = '0;
		row_d = '0;
		case (cmd_q)
			CMD_ACC: begin
				hit_d = qx_hit && qy_hit;
				col_d = qx_idx;
				row_d = qy_idx;
			end
			CMD_RD, CMD_WR: begin
				hit_d = (CNT_W'(cell_col_q) < ncols) && (CNT_W'(cell_row_q) < nrows);
				col_d = cell_col_q;
				row_d = cell_row_q;
			end
			default: ;
		endcase
		addr_d = ADDR_W'(row_d) * ADDR_W'(GRID_COLS) + ADDR_W'(col_d);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RD) begin
			hit_q  <= hit_d;
			col_q  <= col_d;
			row_q  <= row_d;
			addr_q <= addr_d;
		end
	end

	assign rd_data = $signed(rd_raw);
	assign c_ext   = SUM_W'(rd_data);
	assign w_ext   = SUM_W'(weight_q);

	always_comb begin
		case (cmd_q)
			CMD_ACC: src = c_ext + w_ext;
			CMD_WR:  src = w_ext;
			default: src = c_ext;
		endcase
		sat_d   = (src > CELL_HI) || (src < CELL_LO);
		clipped = (src > CELL_HI) ? CELL_HI : ((src < CELL_LO) ? CELL_LO : src);
		val_d   = (clipped > OUT_HI) ? OUT_HI[POS_W-1:0] :
			((clipped < OUT_LO) ? OUT_LO[POS_W-1:0] : clipped[POS_W-1:0]);
	end

	assign mem_ctl.rd_en = (state_q == ST_RD);
	assign mem_ctl.wr_en = (state_q == ST_MOD) && done && hit_q &&
		((cmd_q == CMD_ACC) || (cmd_q == CMD_WR));

	gpa_cell_mem #(
		.DEPTH  (CELL_COUNT),
		.DATA_W (CELL_WIDTH),
		.ADDR_W (ADDR_W)
	) u_cell_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mem_ctl),
		.rd_addr (addr_d),
		.wr_addr (addr_q),
		.wr_data (clipped[CELL_WIDTH-1:0]),
		.rd_data (rd_raw),
		.busy    (mem_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_hit_q   <= 1'b0;
			out_sat_q   <= 1'b0;
			out_val_q   <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
		end else begin
			if ((state_q == ST_MOD) && done) begin
				out_valid_q <= 1'b1;
				out_hit_q   <= hit_q;
				out_sat_q   <= hit_q && sat_d;
				out_val_q   <= hit_q ? val_d : '0;
				out_col_q   <= hit_q ? col_q : '0;
				out_row_q   <= hit_q ? row_q : '0;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_Q1;
					end
				end
				ST_Q1: state_q <= ST_Q2;
				ST_Q2: state_q <= ST_Q3;
				ST_Q3: state_q <= ST_RD;
				ST_RD: state_q <= ST_MOD;
				ST_MOD: begin
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_row_q, out_col_q, out_val_q};
	assign m_tuser  = {out_sat_q, out_hit_q};

	`GPA_ASSERT_IMPLIES(a_no_req_clear, clk, arst_n, mem_busy, !s_tready)
	`GPA_ASSERT_NEXT(a_req_busy, clk, arst_n, accept, state_q == ST_Q1)
	`GPA_ASSERT_IMPLIES(a_wr_on_hit, clk, arst_n, mem_ctl.wr_en, hit_q && (state_q == ST_MOD))
	`GPA_ASSERT_IMPLIES(a_miss_zero, clk, arst_n, m_tvalid && !out_hit_q,
		(out_val_q == '0) && (out_col_q == '0) && (out_row_q == '0) && !out_sat_q)

endmodule

>>> rtl/core/gpa_quant.sv
// Three-stage coordinate quantizer: offset, scale, round half away from zero, range check.
// Depends on gpa_pkg.
module gpa_quant
	import gpa_pkg::*;
(
	input  logic                     clk,
	input  logic signed [POS_W-1:0]  pos,
	input  logic signed [POS_W-1:0]  origin,
	input  logic [SCALE_W-1:0]       scale,
	input  logic [CNT_W-1:0]         count,
	output logic                     hit_s3,
	output logic [IDX_W-1:0]         idx_s3
);

	localparam int DIFF_W = POS_W + 1;
	localparam int PROD_W = DIFF_W + SCALE_W + 1;
	localparam int T_W    = PROD_W + 1;
	localparam int Q_W    = T_W - 1 - Q_SHIFT;
	localparam logic signed [T_W-1:0] ROUND_HALF = T_W'(2 ** (Q_SHIFT - 1));

	logic signed [DIFF_W-1:0] diff_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [T_W-1:0]    t;
	logic signed [SCALE_W:0]  scale_s;

	assign scale_s = $signed({1'b0, scale});
	assign t       = T_W'(prod_s2) + ROUND_HALF;

	always_ff @(posedge clk) begin
		diff_s1 <= DIFF_W'(pos) - DIFF_W'(origin);
		prod_s2 <= PROD_W'(diff_s1) * PROD_W'(scale_s);
		hit_s3  <= !t[T_W-1] && (t != '0) && (t[T_W-2:Q_SHIFT] < Q_W'(count));
		idx_s3  <= t[Q_SHIFT+IDX_W-1:Q_SHIFT];
	end

endmodule

>>> rtl/core/gpa_cell_mem.sv
// Cell store: single-port-write, registered-read memory with a clearing sweep after reset.
// Depends on gpa_pkg for the control struct.
module gpa_cell_mem
	import gpa_pkg::*;
#(
	parameter int DEPTH  = DEF_GRID_COLS * DEF_GRID_ROWS,
	parameter int DATA_W = DEF_CELL_WIDTH,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gpa_mem_ctl_t      ctl,
	input  logic [ADDR_W-1:0] rd_addr,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	output logic [DATA_W-1:0] rd_data,
	output logic              busy
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [ADDR_W-1:0] clr_addr_q;
	logic              clearing_q;

	assign busy = clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= '0;
		end else if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
